// ----- rtl/aplp_pkg.sv -----
package aplp_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAX_PASSES_DEF  = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PASS_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOOST_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOOST_GAIN   = 2'd2;

    localparam int              PASS_COUNT_W     = 2;
    localparam logic [1:0]      PASS_COUNT_RST   = 2'd2;
    localparam logic            BOOST_ENABLE_RST = 1'b1;

    // Boost gain is kept pre-multiplied by 6 (the 1.2 factor is 6/5)
    localparam int              G6_W            = 19;
    localparam logic [G6_W-1:0] BOOST_GAIN6_RST = 19'd70776;

    // Q30 fixed point
    localparam int     Q30_SHIFT = 30;
    localparam longint ROUND_Q30 = 536870912;

    localparam int               C95_W   = 30;
    localparam logic [C95_W-1:0] C95_Q30 = 30'd1020054733;
    localparam longint           C99_Q30 = 1063004406;

    // Boost scaling: divide by 5 * 2^16 with round half up
    localparam int     BOOST_SHIFT = 16;
    localparam longint BOOST_RND   = 163840;

    // Level curve segments, magnitudes in Q30
    localparam int NUM_SEG = 6;
    localparam int SEG_W   = 3;
    localparam int GAIN_W  = 31;

    localparam longint SEG_BP [NUM_SEG] = '{
        107374, 214748, 107374182, 322122547, 536870912, 1073741824 };
    localparam longint SEG_GAIN [NUM_SEG] = '{
        751619277, 966367642, 1610612736, 1610612736, 966367642, 751619277 };
    localparam longint SEG_OFF [NUM_SEG] = '{
        0, -21475, -150324, -150324, 193123204, 300497387 };

    // Upper magnitude of a segment in sample units
    function automatic longint seg_lim(input int f, input int frac);
        return (SEG_BP[f] << frac) >> Q30_SHIFT;
    endfunction

    function automatic logic [GAIN_W-1:0] seg_gain_of(input logic [SEG_W-1:0] seg);
        logic [GAIN_W-1:0] g;
        g = '0;
        if (seg < SEG_W'(NUM_SEG))
            g = GAIN_W'(SEG_GAIN[seg]);
        return g;
    endfunction

    // Segment offset scaled up to the Q30 product domain
    function automatic longint seg_off_of(input logic [SEG_W-1:0] seg, input int frac);
        longint o;
        o = 0;
        if (seg < SEG_W'(NUM_SEG))
            o = SEG_OFF[seg] * (longint'(1) << frac);
        return o;
    endfunction

    // Level returned for magnitudes above full scale
    function automatic longint sat_level(input int frac);
        return ((C99_Q30 << frac) + ROUND_Q30) >>> Q30_SHIFT;
    endfunction

endpackage

// ----- rtl/aplp_curve_pass.sv -----
module aplp_curve_pass #(
    parameter int SAMPLE_BITS = aplp_pkg::SAMPLE_BITS_DEF,
    parameter int WORD_W      = aplp_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pass_en,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word
);
    import aplp_pkg::*;

    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int VAL_W  = SAMPLE_BITS + 2;
    localparam int MAG_W  = FRAC + 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [VAL_W-1:0] SAT_V  = VAL_W'(sat_level(FRAC));
    localparam logic signed [VAL_W-1:0] FULL_V = VAL_W'(longint'(1) << FRAC);

    // Stage registers: A = segment select, B = gain product, C = result
    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    logic [WORD_W-1:0] a_word_reg, b_word_reg, c_word_reg;
    logic              a_neg_reg, b_neg_reg;
    logic              a_sat_reg, b_sat_reg;
    logic [SEG_W-1:0]  a_seg_reg, b_seg_reg;
    logic [MAG_W-1:0]  a_mag_reg;
    logic [PROD_W-1:0] b_prod_reg;

    logic en_a, en_b, en_c;

    logic signed [VAL_W-1:0] in_val;
    logic [VAL_W-1:0]        a_mag_full;
    logic                    a_neg_next, a_sat_next;
    logic [SEG_W-1:0]        a_seg_next;
    logic [PROD_W-1:0]       b_prod_next;
    logic signed [SUM_W-1:0] c_sum;
    logic signed [VAL_W-1:0] c_res, c_curve;
    logic [WORD_W-1:0]       c_word_next;

    // Per-stage advance; a stage moves when empty or when the next one moves
    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    assign out_valid = c_valid_reg;
    assign out_word  = c_word_reg;

    // Stage A: sign, magnitude and segment search
    assign in_val = $signed(in_word[VAL_W-1:0]);

    always_comb
    begin
        a_neg_next = in_val[VAL_W-1];
        a_mag_full = a_neg_next ? VAL_W'(-in_val) : VAL_W'(in_val);
        a_seg_next = SEG_W'(NUM_SEG - 1);
        for (int f = NUM_SEG - 1; f >= 0; f--)
        begin
            if (longint'(a_mag_full) <= seg_lim(f, FRAC))
                a_seg_next = SEG_W'(f);
        end
        a_sat_next = !(longint'(a_mag_full) <= seg_lim(NUM_SEG - 1, FRAC));
    end

    // Stage B: magnitude times segment gain
    assign b_prod_next = PROD_W'(a_mag_reg) * PROD_W'(seg_gain_of(a_seg_reg));

    // Stage C: add offset, round, restore sign, clamp above full scale; bypass when pass_en is low
    always_comb
    begin
        c_sum = $signed({1'b0, b_prod_reg}) + SUM_W'(seg_off_of(b_seg_reg, FRAC))
              + SUM_W'(ROUND_Q30);
        c_res = VAL_W'(c_sum >>> Q30_SHIFT);
        if (b_sat_reg)
            c_curve = b_neg_reg ? -SAT_V : SAT_V;
        else
            c_curve = b_neg_reg ? -c_res : c_res;
        c_word_next = b_word_reg;
        if (pass_en)
            c_word_next[VAL_W-1:0] = c_curve;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= in_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
            if (en_c)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_word_reg <= in_word;
            a_neg_reg  <= a_neg_next;
            a_sat_reg  <= a_sat_next;
            a_seg_reg  <= a_seg_next;
            a_mag_reg  <= a_mag_full[MAG_W-1:0];
        end
        if (en_b)
        begin
            b_word_reg <= a_word_reg;
            b_neg_reg  <= a_neg_reg;
            b_sat_reg  <= a_sat_reg;
            b_seg_reg  <= a_seg_reg;
            b_prod_reg <= b_prod_next;
        end
        if (en_c)
            c_word_reg <= c_word_next;
    end

    // Checks
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted beat did not reach stage A");

    b_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !en_c |=> b_valid_reg && $stable(b_prod_reg))
        else $error("stalled product lost or changed");

    c_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && en_c && pass_en |=>
            $signed(c_word_reg[VAL_W-1:0]) <= FULL_V
            && $signed(c_word_reg[VAL_W-1:0]) >= -FULL_V)
        else $error("curve output beyond full scale");

    c_bypass_exact: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && en_c && !pass_en |=> c_word_reg == $past(b_word_reg))
        else $error("disabled pass altered the beat");

endmodule

// ----- rtl/audio_piecewise_leveler_preemphasis_top.sv -----
// Path: MAX_PASSES curve passes, boost stages S0 to S6, MAX_PASSES more passes, output register,
// independent of pass_count; each curve pass is three stages and always occupies its slot.
// Throughput: one sample per cycle while out_ready is high; every stage has its own valid bit
// and advance, so bubbles close up and a held output does not block input while stages have room.
// Reset: valid bits cleared, boost history cleared, registers to pass_count 2,
// boost_enable 1, boost_gain 11796.
module audio_piecewise_leveler_preemphasis_top #(
    parameter int MAX_PASSES  = aplp_pkg::MAX_PASSES_DEF,
    parameter int SAMPLE_BITS = aplp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aplp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aplp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                block_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);
    import aplp_pkg::*;

    localparam int VAL_W   = SAMPLE_BITS + 2;
    localparam int W1      = VAL_W + 1;
    localparam int C95P_W  = SAMPLE_BITS + C95_W + 1;
    localparam int TS_W    = C95P_W + 1;
    localparam int T_W     = SAMPLE_BITS + 1;
    localparam int D_W     = SAMPLE_BITS + 1;
    localparam int DS_W    = D_W + 1;
    localparam int P_W     = D_W + G6_W + 1;
    localparam int NS_W    = P_W + 3;
    localparam int Q_W     = P_W - BOOST_SHIFT;
    localparam int N_W     = Q_W + 2;
    localparam int R_SHIFT = N_W + 3;
    localparam int R_W     = R_SHIFT - 2;
    localparam int M_W     = N_W + R_W;
    localparam int Y_W     = Q_W + 2;

    localparam longint R_RECIP = ((longint'(1) << R_SHIFT) + 4) / 5;
    localparam longint K_OFS   = longint'(1) << (Q_W - 1);
    localparam longint N_BIAS  = BOOST_RND + (longint'(5) << (P_W - 1));

    localparam logic [R_W-1:0]          R_V     = R_W'(R_RECIP);
    localparam logic signed [VAL_W-1:0] OUT_MAX = VAL_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [VAL_W-1:0] OUT_MIN = VAL_W'(-(longint'(1) << (SAMPLE_BITS - 1)));

    // Configuration registers
    logic [PASS_COUNT_W-1:0] pass_count_reg;
    logic                    boost_enable_reg;
    logic [G6_W-1:0]         boost_gain6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_count_reg   <= PASS_COUNT_RST;
            boost_enable_reg <= BOOST_ENABLE_RST;
            boost_gain6_reg  <= BOOST_GAIN6_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PASS_COUNT:   pass_count_reg   <= cfg_data[PASS_COUNT_W-1:0];
                REG_BOOST_ENABLE: boost_enable_reg <= cfg_data[0];
                REG_BOOST_GAIN:   boost_gain6_reg  <= G6_W'({cfg_data, 2'b00})
                                                    + G6_W'({cfg_data, 1'b0});
                default: ;
            endcase
        end
    end

    // Pass enables; counts above MAX_PASSES saturate naturally
    logic [MAX_PASSES-1:0] pass_en;

    // First set of curve passes; block_start rides on top of the value
    logic [MAX_PASSES:0]         s1_valid, s1_ready;
    logic [MAX_PASSES:0][W1-1:0] s1_word;

    // Second set of curve passes
    logic [MAX_PASSES:0]            s2_valid, s2_ready;
    logic [MAX_PASSES:0][VAL_W-1:0] s2_word;

    assign s1_valid[0] = in_valid;
    assign s1_word[0]  = {block_start, VAL_W'(sample_in)};
    assign in_ready    = s1_ready[0];

    for (genvar k = 0; k < MAX_PASSES; k++)
    begin : g_pass
        assign pass_en[k] = int'(pass_count_reg) > k;

        aplp_curve_pass #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WORD_W      (W1)
        ) u_pass_pre (
            .clk       (clk),
            .rst_n     (rst_n),
            .pass_en   (pass_en[k]),
            .in_valid  (s1_valid[k]),
            .in_ready  (s1_ready[k]),
            .in_word   (s1_word[k]),
            .out_valid (s1_valid[k+1]),
            .out_ready (s1_ready[k+1]),
            .out_word  (s1_word[k+1])
        );

        aplp_curve_pass #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WORD_W      (VAL_W)
        ) u_pass_post (
            .clk       (clk),
            .rst_n     (rst_n),
            .pass_en   (pass_en[k]),
            .in_valid  (s2_valid[k]),
            .in_ready  (s2_ready[k]),
            .in_word   (s2_word[k]),
            .out_valid (s2_valid[k+1]),
            .out_ready (s2_ready[k+1]),
            .out_word  (s2_word[k+1])
        );
    end

    // Boost pipeline registers
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg, out_valid_reg;
    logic en_s0, en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_out;

    logic signed [SAMPLE_BITS-1:0] s0_lev_reg, s1_lev_reg, s2_lev_reg;
    logic signed [SAMPLE_BITS-1:0] s3_lev_reg, s4_lev_reg, s5_lev_reg;
    logic                          s0_start_reg, s1_start_reg;
    logic                          s2_on_reg, s3_on_reg, s4_on_reg, s5_on_reg;
    logic signed [C95P_W-1:0]      s0_c95p_reg;
    logic signed [T_W-1:0]         s1_t_reg;
    logic signed [T_W-1:0]         prev_t_reg;
    logic signed [D_W-1:0]         s2_d_reg;
    logic signed [P_W-1:0]         s3_p_reg;
    logic [N_W-1:0]                s4_n_reg;
    logic [M_W-1:0]                s5_m_reg;
    logic signed [VAL_W-1:0]       s6_y_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic signed [SAMPLE_BITS-1:0] s0_lev_next;
    logic signed [C95P_W-1:0]      s0_c95p_next;
    logic signed [TS_W-1:0]        t_sum;
    logic signed [T_W-1:0]         s1_t_next;
    logic signed [DS_W-1:0]        d_sum;
    logic signed [D_W-1:0]         s2_d_next;
    logic                          s2_on_next;
    logic signed [P_W-1:0]         s3_p_next;
    logic signed [NS_W-1:0]        n_sum;
    logic [N_W-1:0]                s4_n_next;
    logic [M_W-1:0]                s5_m_next;
    logic [Q_W-1:0]                quo;
    logic signed [Y_W-1:0]         y_sum;
    logic signed [VAL_W-1:0]       s5_lev_ext;
    logic signed [VAL_W-1:0]       s6_y_next;
    logic signed [VAL_W-1:0]       post_val;
    logic signed [SAMPLE_BITS-1:0] sample_out_next;

    // Advance chain, output end first
    assign en_out = !out_valid_reg || out_ready;
    assign s2_ready[MAX_PASSES] = en_out;
    assign en_s6  = !s6_valid_reg || s2_ready[0];
    assign en_s5  = !s5_valid_reg || en_s6;
    assign en_s4  = !s4_valid_reg || en_s5;
    assign en_s3  = !s3_valid_reg || en_s4;
    assign en_s2  = !s2_valid_reg || en_s3;
    assign en_s1  = !s1_valid_reg || en_s2;
    assign en_s0  = !s0_valid_reg || en_s1;
    assign s1_ready[MAX_PASSES] = en_s0;

    assign s2_valid[0] = s6_valid_reg;
    assign s2_word[0]  = s6_y_reg;

    // S0: leveled sample times 0.95
    assign s0_lev_next  = $signed(s1_word[MAX_PASSES][SAMPLE_BITS-1:0]);
    assign s0_c95p_next = s0_lev_next * $signed({1'b0, C95_Q30});

    // S1: rounded -0.95*lev term, kept as history for the next sample
    assign t_sum     = TS_W'(ROUND_Q30) - TS_W'(s0_c95p_reg);
    assign s1_t_next = T_W'(t_sum >>> Q30_SHIFT);

    // S2: difference against the previous sample's term
    assign d_sum      = DS_W'(s1_lev_reg) + DS_W'(prev_t_reg);
    assign s2_d_next  = $signed(d_sum[D_W-1:0]);
    assign s2_on_next = boost_enable_reg && !s1_start_reg;

    // S3: difference times 6*gain
    assign s3_p_next = s2_d_reg * $signed({1'b0, boost_gain6_reg});

    // S4: round to 2^-16 and bias positive for the divide by five
    assign n_sum     = NS_W'(s3_p_reg) + NS_W'(N_BIAS);
    assign s4_n_next = n_sum[BOOST_SHIFT +: N_W];

    // S5: divide by five through the reciprocal
    assign s5_m_next = M_W'(s4_n_reg) * M_W'(R_V);

    // S6: remove bias and add the boost; boost off or block start passes the level through
    assign quo        = s5_m_reg[R_SHIFT +: Q_W];
    assign y_sum      = Y_W'(s5_lev_reg) + $signed({2'b00, quo}) - Y_W'(K_OFS);
    assign s5_lev_ext = VAL_W'(s5_lev_reg);
    assign s6_y_next  = s5_on_reg ? $signed(y_sum[VAL_W-1:0]) : s5_lev_ext;

    // Output saturation to the sample range
    assign post_val = $signed(s2_word[MAX_PASSES]);

    always_comb
    begin
        if (post_val > OUT_MAX)
            sample_out_next = OUT_MAX[SAMPLE_BITS-1:0];
        else if (post_val < OUT_MIN)
            sample_out_next = OUT_MIN[SAMPLE_BITS-1:0];
        else
            sample_out_next = post_val[SAMPLE_BITS-1:0];
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // Valid bits and boost history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_t_reg    <= '0;
        end
        else
        begin
            if (en_s0)
                s0_valid_reg <= s1_valid[MAX_PASSES];
            if (en_s1)
                s1_valid_reg <= s0_valid_reg;
            if (en_s2)
                s2_valid_reg <= s1_valid_reg;
            if (en_s2 && s1_valid_reg)
                prev_t_reg <= s1_t_reg;
            if (en_s3)
                s3_valid_reg <= s2_valid_reg;
            if (en_s4)
                s4_valid_reg <= s3_valid_reg;
            if (en_s5)
                s5_valid_reg <= s4_valid_reg;
            if (en_s6)
                s6_valid_reg <= s5_valid_reg;
            if (en_out)
                out_valid_reg <= s2_valid[MAX_PASSES];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en_s0)
        begin
            s0_lev_reg   <= s0_lev_next;
            s0_start_reg <= s1_word[MAX_PASSES][VAL_W];
            s0_c95p_reg  <= s0_c95p_next;
        end
        if (en_s1)
        begin
            s1_lev_reg   <= s0_lev_reg;
            s1_start_reg <= s0_start_reg;
            s1_t_reg     <= s1_t_next;
        end
        if (en_s2)
        begin
            s2_lev_reg <= s1_lev_reg;
            s2_on_reg  <= s2_on_next;
            s2_d_reg   <= s2_d_next;
        end
        if (en_s3)
        begin
            s3_lev_reg <= s2_lev_reg;
            s3_on_reg  <= s2_on_reg;
            s3_p_reg   <= s3_p_next;
        end
        if (en_s4)
        begin
            s4_lev_reg <= s3_lev_reg;
            s4_on_reg  <= s3_on_reg;
            s4_n_reg   <= s4_n_next;
        end
        if (en_s5)
        begin
            s5_lev_reg <= s4_lev_reg;
            s5_on_reg  <= s4_on_reg;
            s5_m_reg   <= s5_m_next;
        end
        if (en_s6)
            s6_y_reg <= s6_y_next;
        if (en_out)
            sample_out_reg <= sample_out_next;
    end

    // Checks
    empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input blocked with empty output register");

    history_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && en_s2 |=> prev_t_reg == $past(s1_t_reg))
        else $error("boost history not updated from passing beat");

    start_blocks_boost: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && en_s2 && s1_start_reg |=> !s2_on_reg)
        else $error("boost applied to first sample of a block");

    unboosted_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && en_s6 && !s5_on_reg |=> s6_y_reg == $past(s5_lev_ext))
        else $error("unboosted sample altered in boost stage");

endmodule
